// ===== rtl/itp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itp_pkg
// Types, codes and helper functions shared by the infix-to-postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  // Default depth of the operator stack.
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Input item opcodes.
  localparam logic OPC_CHAR  = 1'b0;
  localparam logic OPC_FLUSH = 1'b1;

  // Operator codes held on the stack.
  localparam logic [2:0] OP_LPAR = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_POW  = 3'd5;

  // Error codes carried on results.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_UNCLOSE  = 2'd2;
  localparam logic [1:0] ERR_UNOPEN   = 2'd3;

  // ASCII characters of interest.
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;

  typedef struct packed {
    logic       opcode;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       last;
    logic [1:0] error;
  } out_item_t;

  // One result handed from the core to the output register.
  typedef struct packed {
    logic      load;
    out_item_t item;
  } emit_t;

  // Letters and digits pass straight through.
  function automatic logic is_alnum(input logic [7:0] s);
    return ((s >= 8'h30) && (s <= 8'h39)) ||
           ((s >= 8'h41) && (s <= 8'h5A)) ||
           ((s >= 8'h61) && (s <= 8'h7A));
  endfunction

  // Character printed for an operator code.
  function automatic logic [7:0] code_char(input logic [2:0] c);
    logic [7:0] r;
    case (c)
      OP_LPAR: r = CH_LPAR;
      OP_ADD:  r = CH_PLUS;
      OP_SUB:  r = CH_MINUS;
      OP_MUL:  r = CH_STAR;
      OP_DIV:  r = CH_SLASH;
      OP_POW:  r = CH_CARET;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Precedence of an operator code.
  function automatic logic [2:0] code_prec(input logic [2:0] c);
    logic [2:0] r;
    case (c)
      OP_ADD, OP_SUB: r = 3'd2;
      OP_MUL, OP_DIV: r = 3'd3;
      OP_POW:         r = 3'd4;
      default:        r = 3'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/itp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// itp_core
// Shunting-yard sequencer around the operator stack memory. It holds the
// most recent emitted character back by one step so that the flags of the
// final result can be attached once the end of the pop sequence is known.
// ----------------------------------------------------------------------------
module itp_core #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire itp_pkg::in_item_t in_item_i,
  output logic                  in_ready_o,
  input  wire logic             out_free_i,
  output itp_pkg::emit_t        emit_o
);
  import itp_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [1:0] K_FLUSH = 2'd0;
  localparam logic [1:0] K_CLOSE = 2'd1;
  localparam logic [1:0] K_OPER  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [1:0]    kind_q, kind_d;
  logic [CW-1:0] count_q, count_d;
  logic [2:0]    code_q, code_d;
  logic [7:0]    pend_q, pend_d;
  logic          pend_v_q, pend_v_d;
  logic          mark_q, mark_d;
  logic [1:0]    err_q, err_d;

  // Stack memory with a registered read port.
  logic [2:0]    mem [STACK_DEPTH];
  logic [2:0]    rdata_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [2:0]    wr_data;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic          sym_op_v;
  logic [2:0]    sym_op;
  logic          do_pop, emit_chr, pop_ok, more;
  logic [2:0]    top_prec, new_prec;

  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);

  // Operator decode of the incoming symbol.
  always_comb begin
    sym_op_v = 1'b1;
    unique case (in_item_i.symbol)
      CH_LPAR:  sym_op = OP_LPAR;
      CH_PLUS:  sym_op = OP_ADD;
      CH_MINUS: sym_op = OP_SUB;
      CH_STAR:  sym_op = OP_MUL;
      CH_SLASH: sym_op = OP_DIV;
      CH_CARET: sym_op = OP_POW;
      default: begin
        sym_op   = OP_LPAR;
        sym_op_v = 1'b0;
      end
    endcase
  end

  // The stacked operator leaves if it binds at least as tightly; ^ is
  // right-associative, so an equal ^ stays.
  assign top_prec = code_prec(rdata_q);
  assign new_prec = code_prec(code_q);
  assign pop_ok   = (rdata_q != OP_LPAR) &&
                    ((top_prec > new_prec) || ((top_prec == new_prec) && (code_q != OP_POW)));

  assign in_ready_o = (state_q == S_IDLE) && out_free_i;

  // Sequencer. A push is written to the memory before the next read is
  // issued, so the memory needs no forwarding path.
  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    count_d  = count_q;
    code_d   = code_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    mark_d   = mark_q;
    err_d    = err_q;
    rd_en    = 1'b0;
    rd_addr  = cnt_m1[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = count_q[AW-1:0];
    wr_data  = code_q;
    emit_o   = '0;
    do_pop   = 1'b0;
    emit_chr = 1'b0;
    more     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          pend_v_d = 1'b0;
          mark_d   = 1'b0;
          err_d    = ERR_NONE;
          if (in_item_i.opcode == OPC_FLUSH) begin
            if (count_q == '0) begin
              emit_o.load          = 1'b1;
              emit_o.item.last     = 1'b1;
            end else begin
              rd_en   = 1'b1;
              kind_d  = K_FLUSH;
              state_d = S_POP;
            end
          end else if (is_alnum(in_item_i.symbol)) begin
            emit_o.load          = 1'b1;
            emit_o.item.out_char = in_item_i.symbol;
            emit_o.item.has_char = 1'b1;
          end else if (in_item_i.symbol == CH_RPAR) begin
            if (count_q == '0) begin
              emit_o.load       = 1'b1;
              emit_o.item.error = ERR_UNCLOSE;
            end else begin
              rd_en   = 1'b1;
              kind_d  = K_CLOSE;
              state_d = S_POP;
            end
          end else if (sym_op_v) begin
            if ((sym_op == OP_LPAR) || (count_q == '0)) begin
              if (count_q == FULL) begin
                emit_o.load       = 1'b1;
                emit_o.item.error = ERR_OVERFLOW;
              end else begin
                wr_en   = 1'b1;
                wr_data = sym_op;
                count_d = count_q + CW'(1);
              end
            end else begin
              rd_en   = 1'b1;
              kind_d  = K_OPER;
              code_d  = sym_op;
              state_d = S_POP;
            end
          end
        end
      end

      S_POP: begin
        if (out_free_i) begin
          case (kind_q)
            K_FLUSH, K_CLOSE: begin
              do_pop   = 1'b1;
              emit_chr = (rdata_q != OP_LPAR);
            end
            K_OPER: begin
              do_pop   = pop_ok;
              emit_chr = pop_ok;
            end
            default: begin
              do_pop   = 1'b0;
              emit_chr = 1'b0;
            end
          endcase

          // The held character is now known not to be the final one.
          if (emit_chr) begin
            if (pend_v_q) begin
              emit_o.load          = 1'b1;
              emit_o.item.out_char = pend_q;
              emit_o.item.has_char = 1'b1;
            end
            pend_d   = code_char(rdata_q);
            pend_v_d = 1'b1;
          end
          if (do_pop) begin
            count_d = cnt_m1;
          end

          more = do_pop && (cnt_m1 != '0) &&
                 !((kind_q == K_CLOSE) && (rdata_q == OP_LPAR));
          if (kind_q == K_FLUSH && rdata_q == OP_LPAR) begin
            err_d = ERR_UNOPEN;
          end

          if (more) begin
            rd_en   = 1'b1;
            rd_addr = cnt_m2[AW-1:0];
          end else begin
            state_d = S_FIN;
            case (kind_q)
              K_FLUSH: mark_d = !(pend_v_q || emit_chr);
              K_CLOSE: begin
                if (rdata_q != OP_LPAR) begin
                  err_d = ERR_UNCLOSE;
                end
              end
              default: begin
                // Push the new operator onto what the pops left.
                wr_addr = count_d[AW-1:0];
                if (count_d == FULL) begin
                  mark_d = 1'b1;
                  err_d  = ERR_OVERFLOW;
                end else begin
                  wr_en   = 1'b1;
                  count_d = count_d + CW'(1);
                end
              end
            endcase
          end
        end
      end

      S_FIN: begin
        if (out_free_i) begin
          if (pend_v_q) begin
            emit_o.load          = 1'b1;
            emit_o.item.out_char = pend_q;
            emit_o.item.has_char = 1'b1;
            emit_o.item.last     = (kind_q == K_FLUSH);
            emit_o.item.error    = (kind_q == K_OPER) ? ERR_NONE : err_q;
            pend_v_d = 1'b0;
            if (!mark_q) begin
              state_d = S_IDLE;
            end
          end else begin
            if (mark_q) begin
              emit_o.load       = 1'b1;
              emit_o.item.last  = (kind_q == K_FLUSH);
              emit_o.item.error = err_q;
            end
            mark_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= K_FLUSH;
      count_q  <= '0;
      pend_v_q <= 1'b0;
      mark_q   <= 1'b0;
      err_q    <= ERR_NONE;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      count_q  <= count_d;
      pend_v_q <= pend_v_d;
      mark_q   <= mark_d;
      err_q    <= err_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    pend_q <= pend_d;
  end

  // Stack memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/infix_to_postfix_converter.sv =====
`default_nettype none
// A letter or digit appears in the output register in the cycle after its transfer.
// A ')' or flush issues the stack read, pops the entries one by one and then closes.
// An operator also examines the entry that stops its pops, and an overflow marker takes a
// further step; '(' or an operator onto an empty stack is pushed on its transfer. Output
// stalls hold each of these steps, and all results pass through one output register.
// Reset empties the stack at once; the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Converts an infix character stream to postfix with a bounded operator
// stack, flagging overflow and unmatched parentheses.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire itp_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output itp_pkg::out_item_t     out_item_o
);
  import itp_pkg::*;

  logic      out_v_q, out_v_d;
  out_item_t out_item_q;
  logic      out_free;
  logic      in_ready;
  emit_t     emit;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_v_q || !out_stall_i;

  itp_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .in_ready_o(in_ready),
    .out_free_i(out_free),
    .emit_o    (emit)
  );

  assign in_stall_o = !in_ready;

  // Output register valid flag.
  always_comb begin
    out_v_d = out_v_q;
    if (emit.load) begin
      out_v_d = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  // Output payload, loaded only when the previous transfer is done.
  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_item_q <= emit.item;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Infix-to-postfix converter testbench
// Sends infix character streams into the converter and checks every postfix
// result transfer against a shunting-yard predictor kept in step with the
// accepted input. Directed expressions come first, then random well-formed,
// deeply nested, broken and noisy expressions under random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int unsigned STACK_SLOTS = STACK_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 430;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_item_t  in_item     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_item_t out_item;

  infix_to_postfix_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // Items waiting to be sent and postfix results waiting to arrive.
  in_item_t  pending_items[$];
  out_item_t postfix_due[$];

  // Shadow copy of the operator stack.
  logic [2:0]  shadow_stack [0:STACK_SLOTS-1];
  int unsigned shadow_depth = 0;

  // Run statistics.
  int unsigned n_in_xfers   = 0;
  int unsigned n_flushes    = 0;
  int unsigned n_out_xfers  = 0;
  int unsigned n_overflow   = 0;
  int unsigned n_unclose    = 0;
  int unsigned n_unopen     = 0;
  int unsigned n_failures   = 0;
  int unsigned n_meaningful = 0;

  // Sender burst and gap bookkeeping.
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;

  // Receiver stall pattern bookkeeping.
  int unsigned stall_mode  = 0;
  int unsigned stall_phase = 0;
  logic        stall_toggle = 1'b0;

  // Clock generation.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Letters and digits are operands.
  function automatic bit is_operand(input logic [7:0] s);
    return (s >= "0" && s <= "9") || (s >= "A" && s <= "Z") || (s >= "a" && s <= "z");
  endfunction

  // Binding strength of a stacked operator.
  function automatic int unsigned op_rank(input logic [2:0] c);
    case (c)
      OP_ADD, OP_SUB: return 2;
      OP_MUL, OP_DIV: return 3;
      OP_POW:         return 4;
      default:        return 0;
    endcase
  endfunction

  // Character emitted for a stacked operator.
  function automatic logic [7:0] op_symbol(input logic [2:0] c);
    case (c)
      OP_ADD:  return CH_PLUS;
      OP_SUB:  return CH_MINUS;
      OP_MUL:  return CH_STAR;
      OP_DIV:  return CH_SLASH;
      OP_POW:  return CH_CARET;
      default: return CH_LPAR;
    endcase
  endfunction

  function automatic out_item_t make_result(input logic [7:0] ch, input logic has,
                                            input logic fin, input logic [1:0] err);
    out_item_t r;
    r.out_char = ch;
    r.has_char = has;
    r.last     = fin;
    r.error    = err;
    return r;
  endfunction

  // Shunting-yard step: updates the shadow stack and queues the postfix results.
  task automatic convert_item(input in_item_t it);
    out_item_t   batch [0:STACK_SLOTS];
    out_item_t   r;
    int unsigned n;
    bit          found;
    bit          popping;
    bit          is_op;
    logic [2:0]  code;
    logic [2:0]  top;
    logic [1:0]  flush_err;
    n = 0;
    if (it.opcode == OPC_FLUSH) begin
      // End of expression: drain the stack, dropping any '('.
      n_flushes++;
      flush_err = ERR_NONE;
      while (shadow_depth > 0) begin
        shadow_depth--;
        top = shadow_stack[shadow_depth];
        if (top == OP_LPAR) begin
          flush_err = ERR_UNOPEN;
        end else begin
          batch[n] = make_result(op_symbol(top), 1'b1, 1'b0, ERR_NONE);
          n++;
        end
      end
      if (n == 0) begin
        batch[0] = make_result(8'h00, 1'b0, 1'b1, flush_err);
        n = 1;
      end else begin
        r = batch[n-1];
        r.last  = 1'b1;
        r.error = flush_err;
        batch[n-1] = r;
      end
    end else if (is_operand(it.symbol)) begin
      batch[0] = make_result(it.symbol, 1'b1, 1'b0, ERR_NONE);
      n = 1;
    end else if (it.symbol == CH_RPAR) begin
      // Closing parenthesis: pop down to the matching '('.
      found = 1'b0;
      while (!found && shadow_depth > 0) begin
        shadow_depth--;
        top = shadow_stack[shadow_depth];
        if (top == OP_LPAR) begin
          found = 1'b1;
        end else begin
          batch[n] = make_result(op_symbol(top), 1'b1, 1'b0, ERR_NONE);
          n++;
        end
      end
      if (!found) begin
        if (n == 0) begin
          batch[0] = make_result(8'h00, 1'b0, 1'b0, ERR_UNCLOSE);
          n = 1;
        end else begin
          r = batch[n-1];
          r.error = ERR_UNCLOSE;
          batch[n-1] = r;
        end
      end
    end else begin
      is_op = 1'b1;
      code  = OP_LPAR;
      case (it.symbol)
        CH_LPAR:  code = OP_LPAR;
        CH_PLUS:  code = OP_ADD;
        CH_MINUS: code = OP_SUB;
        CH_STAR:  code = OP_MUL;
        CH_SLASH: code = OP_DIV;
        CH_CARET: code = OP_POW;
        default:  is_op = 1'b0;
      endcase
      if (is_op) begin
        // Operators pop stronger ones, and equal ones unless right-associative.
        if (code != OP_LPAR) begin
          popping = 1'b1;
          while (popping && shadow_depth > 0) begin
            top = shadow_stack[shadow_depth-1];
            if (top != OP_LPAR && (op_rank(top) > op_rank(code) ||
                (op_rank(top) == op_rank(code) && code != OP_POW))) begin
              shadow_depth--;
              batch[n] = make_result(op_symbol(top), 1'b1, 1'b0, ERR_NONE);
              n++;
            end else begin
              popping = 1'b0;
            end
          end
        end
        if (shadow_depth >= STACK_SLOTS) begin
          batch[n] = make_result(8'h00, 1'b0, 1'b0, ERR_OVERFLOW);
          n++;
        end else begin
          shadow_stack[shadow_depth] = code;
          shadow_depth++;
        end
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      postfix_due.push_back(batch[i]);
    end
  endtask

  // Stimulus helpers.
  function automatic void queue_char(input logic [7:0] s);
    in_item_t it;
    it.opcode = OPC_CHAR;
    it.symbol = s;
    pending_items.push_back(it);
    if (is_operand(s) || s == CH_LPAR || s == CH_RPAR || s == CH_PLUS || s == CH_MINUS ||
        s == CH_STAR || s == CH_SLASH || s == CH_CARET) begin
      n_meaningful++;
    end
  endfunction

  function automatic void queue_flush();
    in_item_t it;
    it.opcode = OPC_FLUSH;
    it.symbol = 8'($urandom_range(0, 255));
    pending_items.push_back(it);
    n_meaningful++;
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s[i]);
    end
  endfunction

  function automatic logic [7:0] random_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("a" + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  // Builds a well-formed infix expression with random nesting.
  function automatic string random_expression();
    string       s;
    int unsigned terms;
    int unsigned open;
    s     = "";
    open  = 0;
    terms = $urandom_range(1, 8);
    for (int unsigned i = 0; i < terms; i++) begin
      while (open < 5 && $urandom_range(0, 3) == 0) begin
        s = {s, "("};
        open++;
      end
      s = {s, string'(random_operand())};
      while (open > 0 && $urandom_range(0, 2) == 0) begin
        s = {s, ")"};
        open--;
      end
      if (i + 1 < terms) begin
        s = {s, string'(random_operator())};
      end
    end
    while (open > 0) begin
      s = {s, ")"};
      open--;
    end
    return s;
  endfunction

  // Driver: sends pending items in bursts separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        n_in_xfers++;
        convert_item(in_item);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the output on a changing pattern and checks each transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out_xfers++;
        if (postfix_due.size() == 0) begin
          n_failures++;
          $display("%0t: unexpected result transfer, expected none, actual %h",
                   $realtime, out_item);
        end else begin
          want = postfix_due.pop_front();
          if (want.error == ERR_OVERFLOW) n_overflow++;
          if (want.error == ERR_UNCLOSE)  n_unclose++;
          if (want.error == ERR_UNOPEN)   n_unopen++;
          if (out_item.out_char !== want.out_char) begin
            n_failures++;
            $display("%0t: out_char mismatch, expected %h, actual %h",
                     $realtime, want.out_char, out_item.out_char);
          end
          if (out_item.has_char !== want.has_char) begin
            n_failures++;
            $display("%0t: has_char mismatch, expected %b, actual %b",
                     $realtime, want.has_char, out_item.has_char);
          end
          if (out_item.last !== want.last) begin
            n_failures++;
            $display("%0t: last mismatch, expected %b, actual %b",
                     $realtime, want.last, out_item.last);
          end
          if (out_item.error !== want.error) begin
            n_failures++;
            $display("%0t: error mismatch, expected %0d, actual %0d",
                     $realtime, want.error, out_item.error);
          end
        end
      end
      // A new stall pattern is chosen when the current one's phase runs out.
      if (stall_phase == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_phase = $urandom_range(20, 120);
      end else begin
        stall_phase--;
      end
      stall_toggle = ~stall_toggle;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= stall_toggle;
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    string       s;
    int unsigned pick;
    int unsigned idx;
    int unsigned mode;
    int unsigned k;

    // Directed: every operand extreme and operator, then the error cases.
    queue_text("A+z*0^9^Z-a/b");
    queue_flush();
    queue_char(CH_RPAR);
    queue_text("a-b)");
    queue_char(CH_LPAR);
    queue_flush();
    queue_flush();
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_flush();

    // Random part.
    n_meaningful = 0;
    while (n_meaningful < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_text(random_expression());
        queue_flush();
      end else if (pick < 65) begin
        // Deep nesting that can run the stack past its depth.
        k = $urandom_range(14, 20);
        for (int unsigned i = 0; i < k; i++) begin
          case ($urandom_range(0, 2))
            0:       queue_char(CH_LPAR);
            1:       queue_char(CH_CARET);
            default: queue_char(random_operand());
          endcase
        end
        k = $urandom_range(0, 6);
        for (int unsigned i = 0; i < k; i++) begin
          queue_char(CH_RPAR);
        end
        queue_flush();
      end else if (pick < 80) begin
        // Broken expression: one character dropped or a stray parenthesis added.
        s    = random_expression();
        idx  = $urandom_range(0, s.len() - 1);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < s.len(); i++) begin
          if (i == idx && mode == 1) queue_char(CH_LPAR);
          if (i == idx && mode == 2) queue_char(CH_RPAR);
          if (!(i == idx && mode == 0)) queue_char(s[i]);
        end
        queue_flush();
      end else if (pick < 92) begin
        // Noise bytes over the whole character range.
        k = $urandom_range(1, 6);
        for (int unsigned i = 0; i < k; i++) begin
          queue_char(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) == 0) queue_flush();
      end else begin
        queue_flush();
      end
    end

    // Reset is held, then released.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all input to go in and all results to come out.
    while (pending_items.size() != 0 || in_valid) @(posedge clk_i);
    while (postfix_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (postfix_due.size() != 0) begin
      n_failures++;
      $display("%0t: %0d results still expected, actual none", $realtime,
               postfix_due.size());
    end

    $display("Converted %0d input transfers (%0d end-of-expression) into %0d result transfers.",
             n_in_xfers, n_flushes, n_out_xfers);
    $display("Flags checked: %0d overflow, %0d unmatched close, %0d unmatched open.",
             n_overflow, n_unclose, n_unopen);
    if (n_failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("Timed out with %0d items unsent and %0d results outstanding.",
             pending_items.size(), postfix_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/itp_pkg.sv
rtl/itp_core.sv
rtl/infix_to_postfix_converter.sv
dv/testbench.sv
